@@ rtl/apsp_pkg.sv @@
package apsp_pkg;

	// sample and result widths
	localparam int SAMPLE_BITS = 16;
	localparam int POWER_W     = 2 * SAMPLE_BITS;
	localparam int SUM_W       = 40;
	localparam int AVG_W       = 32;
	localparam int IDX_W       = 10;

	// configuration port
	localparam int BINS_CFG_W = 11;
	localparam int VECS_CFG_W = 9;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;

	localparam logic [BINS_CFG_W-1:0] BINS_RESET = 11'd1024;
	localparam logic [VECS_CFG_W-1:0] VECS_RESET = 9'd8;

	// parameter defaults
	localparam int MAX_BINS_DEF    = 1024;
	localparam int MAX_VECTORS_DEF = 256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BINS_IN_USE = 1'b0,
		REG_VECTORS     = 1'b1
	} cfg_reg_t;

	// position flags that travel with each word
	typedef struct packed {
		logic first_v;
		logic last_v;
		logic last_b;
	} pos_flags_t;

	// magnitude of a two's complement sample
	function automatic logic [SAMPLE_BITS-1:0] sample_mag(input logic [SAMPLE_BITS-1:0] v);
		logic [SAMPLE_BITS-1:0] r;
		r = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

@@ rtl/apsp_if.sv @@
interface apsp_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [apsp_pkg::SAMPLE_BITS-1:0]  sample_real;
	logic signed [apsp_pkg::SAMPLE_BITS-1:0]  sample_imag;

	modport source (output valid, output sample_real, output sample_imag, input ready);
	modport sink (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface apsp_out_if;
	logic                             valid;
	logic                             ready;
	logic [apsp_pkg::AVG_W-1:0]       bin_average;
	logic [apsp_pkg::IDX_W-1:0]       bin_index;
	logic                             last_bin;

	modport source (output valid, output bin_average, output bin_index, output last_bin,
		input ready);
	modport sink (input valid, input bin_average, input bin_index, input last_bin,
		output ready);
endinterface

@@ rtl/apsp_ram.sv @@
module apsp_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/apsp_fifo.sv @@
module apsp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4,
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

	// hold words
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/apsp_front.sv @@
module apsp_front #(
	parameter int MAX_BINS    = apsp_pkg::MAX_BINS_DEF,
	parameter int MAX_VECTORS = apsp_pkg::MAX_VECTORS_DEF,
	localparam int BIN_W  = $clog2(MAX_BINS),
	localparam int BCNT_W = $clog2(MAX_BINS + 1),
	localparam int VCNT_W = $clog2(MAX_VECTORS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	apsp_in_if.sink                        in_ch,
	input  logic [BCNT_W-1:0]              nb,
	input  logic [VCNT_W-1:0]              nv,
	output logic                           push_valid,
	input  logic                           push_ready,
	output logic [apsp_pkg::POWER_W-1:0]   push_power,
	output logic [BIN_W-1:0]               push_bin,
	output apsp_pkg::pos_flags_t           push_flags
);
	import apsp_pkg::*;

	localparam int VEC_W = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;

	logic [BIN_W-1:0]         bin_q;
	logic [VEC_W-1:0]         vec_q;
	logic                     advance;
	logic                     accept;
	pos_flags_t               flags;

	logic                     v_s1;
	logic [SAMPLE_BITS-1:0]   re_s1;
	logic [SAMPLE_BITS-1:0]   im_s1;
	logic [BIN_W-1:0]         bin_s1;
	pos_flags_t               flags_s1;

	logic                     v_s2;
	logic [POWER_W-1:0]       sqr_re_s2;
	logic [POWER_W-1:0]       sqr_im_s2;
	logic [BIN_W-1:0]         bin_s2;
	pos_flags_t               flags_s2;

	// both stages move together; stall when the queue is full
	assign advance     = !v_s2 || push_ready;
	assign in_ch.ready = advance;
	assign accept      = in_ch.valid && advance;

	// classify the word by its place in the group
	always_comb begin
		flags.first_v = (vec_q == '0);
		flags.last_v  = (int'(vec_q) >= int'(nv) - 1);
		flags.last_b  = (int'(bin_q) >= int'(nb) - 1);
	end

	// advance bin and vector positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			vec_q <= '0;
		end else if (accept) begin
			if (flags.last_b) begin
				bin_q <= '0;
				vec_q <= flags.last_v ? '0 : VEC_W'(vec_q + 1'b1);
			end else begin
				bin_q <= BIN_W'(bin_q + 1'b1);
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// magnitudes, then squares
	always_ff @(posedge clk) begin
		if (advance) begin
			re_s1     <= sample_mag(in_ch.sample_real);
			im_s1     <= sample_mag(in_ch.sample_imag);
			bin_s1    <= bin_q;
			flags_s1  <= flags;
			sqr_re_s2 <= re_s1 * re_s1;
			sqr_im_s2 <= im_s1 * im_s1;
			bin_s2    <= bin_s1;
			flags_s2  <= flags_s1;
		end
	end

	assign push_valid = v_s2;
	assign push_power = sqr_re_s2 + sqr_im_s2;
	assign push_bin   = bin_s2;
	assign push_flags = flags_s2;

endmodule

@@ rtl/apsp_back.sv @@
module apsp_back #(
	parameter int MAX_BINS    = apsp_pkg::MAX_BINS_DEF,
	parameter int MAX_VECTORS = apsp_pkg::MAX_VECTORS_DEF,
	localparam int BIN_W  = $clog2(MAX_BINS),
	localparam int VCNT_W = $clog2(MAX_VECTORS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  logic [apsp_pkg::POWER_W-1:0]   pop_power,
	input  logic [BIN_W-1:0]               pop_bin,
	input  apsp_pkg::pos_flags_t           pop_flags,
	input  logic [VCNT_W-1:0]              nv,
	apsp_out_if.source                     out_ch
);
	import apsp_pkg::*;

	localparam int CNT_W = $clog2(SUM_W);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ACC  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} back_state_t;

	back_state_t          state_q;
	logic [POWER_W-1:0]   power_q;
	logic [BIN_W-1:0]     bin_q;
	pos_flags_t           flags_q;
	logic [SUM_W-1:0]     rd_sum;
	logic [SUM_W-1:0]     new_sum;
	logic [SUM_W-1:0]     div_q;
	logic [VCNT_W-1:0]    rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [VCNT_W:0]      trial;
	logic                 q_bit;
	logic [VCNT_W-1:0]    rem_next;
	logic                 do_pop;
	logic                 do_load;
	logic                 out_v_q;
	logic [AVG_W-1:0]     avg_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 last_q;

	assign pop_ready = (state_q == ST_IDLE);
	assign do_pop    = pop_valid && pop_ready;
	assign do_load   = (state_q == ST_OUT) && (!out_v_q || out_ch.ready);

	// first vector of a group overwrites the running sum
	assign new_sum = flags_q.first_v ? SUM_W'(power_q) : rd_sum + SUM_W'(power_q);

	apsp_ram #(
		.W (SUM_W),
		.D (MAX_BINS)
	) u_sums (
		.clk   (clk),
		.we    (state_q == ST_ACC),
		.waddr (bin_q),
		.wdata (new_sum),
		.re    (do_pop),
		.raddr (pop_bin),
		.rdata (rd_sum)
	);

	// one restoring quotient bit per cycle
	always_comb begin
		trial    = {rem_q, div_q[SUM_W-1]};
		q_bit    = (trial >= (VCNT_W + 1)'(nv));
		rem_next = q_bit ? VCNT_W'(trial - (VCNT_W + 1)'(nv)) : VCNT_W'(trial);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_pop) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					cnt_q   <= '0;
					state_q <= flags_q.last_v ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					cnt_q <= CNT_W'(cnt_q + 1'b1);
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (do_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the word being worked and the divider registers
	always_ff @(posedge clk) begin
		if (do_pop) begin
			power_q <= pop_power;
			bin_q   <= pop_bin;
			flags_q <= pop_flags;
		end
		if (state_q == ST_ACC) begin
			div_q <= new_sum;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_q <= {div_q[SUM_W-2:0], q_bit};
			rem_q <= rem_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (do_load) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			avg_q  <= div_q[AVG_W-1:0];
			idx_q  <= IDX_W'(bin_q);
			last_q <= flags_q.last_b;
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.bin_average = avg_q;
	assign out_ch.bin_index   = idx_q;
	assign out_ch.last_bin    = last_q;

endmodule

@@ rtl/averaged_power_spectrum_top.sv @@
// Channel   Role    Word
// in_ch     sink    sample_real, sample_imag (signed)
// out_ch    source  bin_average, bin_index, last_bin
// wr_*      write   register index 0 bins_in_use, 1 vectors_to_average
//
// In the back end, a word outside the last vector of a group has its sum read,
// then written back to the per-bin sum memory.
// A word of the last vector also has its new sum divided by the vector count;
// the divide produces one quotient bit per cycle over the 40-bit sum.
// The front end squares words in two stages and a four-word queue lets it run
// ahead; it stalls only when that queue is full.
// Reset clears positions, queue and output register; the sum memory is not cleared.
module averaged_power_spectrum_top #(
	parameter int MAX_BINS    = apsp_pkg::MAX_BINS_DEF,
	parameter int MAX_VECTORS = apsp_pkg::MAX_VECTORS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [apsp_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [apsp_pkg::CFG_W-1:0]       wr_data,
	apsp_in_if.sink                          in_ch,
	apsp_out_if.source                       out_ch
);
	import apsp_pkg::*;

	localparam int BIN_W   = $clog2(MAX_BINS);
	localparam int BCNT_W  = $clog2(MAX_BINS + 1);
	localparam int VCNT_W  = $clog2(MAX_VECTORS + 1);
	localparam int FLAGS_W = $bits(pos_flags_t);
	localparam int Q_W     = POWER_W + BIN_W + FLAGS_W;

	logic [BINS_CFG_W-1:0] bins_q;
	logic [VECS_CFG_W-1:0] vecs_q;
	logic [BCNT_W-1:0]     nb;
	logic [VCNT_W-1:0]     nv;

	logic                  push_valid;
	logic                  push_ready;
	logic [POWER_W-1:0]    push_power;
	logic [BIN_W-1:0]      push_bin;
	pos_flags_t            push_flags;
	logic                  pop_valid;
	logic                  pop_ready;
	logic [Q_W-1:0]        pop_data;
	pos_flags_t            pop_flags;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= BINS_RESET;
			vecs_q <= VECS_RESET;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_BINS_IN_USE: bins_q <= wr_data[BINS_CFG_W-1:0];
				REG_VECTORS:     vecs_q <= wr_data[VECS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		if (bins_q == '0) begin
			nb = BCNT_W'(1);
		end else if (int'(bins_q) > MAX_BINS) begin
			nb = BCNT_W'(MAX_BINS);
		end else begin
			nb = BCNT_W'(bins_q);
		end
		if (vecs_q == '0) begin
			nv = VCNT_W'(1);
		end else if (int'(vecs_q) > MAX_VECTORS) begin
			nv = VCNT_W'(MAX_VECTORS);
		end else begin
			nv = VCNT_W'(vecs_q);
		end
	end

	apsp_front #(
		.MAX_BINS    (MAX_BINS),
		.MAX_VECTORS (MAX_VECTORS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.nb         (nb),
		.nv         (nv),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_power (push_power),
		.push_bin   (push_bin),
		.push_flags (push_flags)
	);

	apsp_fifo #(
		.W     (Q_W),
		.DEPTH (4)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_power, push_bin, push_flags}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_flags = pos_flags_t'(pop_data[FLAGS_W-1:0]);

	apsp_back #(
		.MAX_BINS    (MAX_BINS),
		.MAX_VECTORS (MAX_VECTORS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_power (pop_data[Q_W-1 -: POWER_W]),
		.pop_bin   (pop_data[FLAGS_W +: BIN_W]),
		.pop_flags (pop_flags),
		.nv        (nv),
		.out_ch    (out_ch)
	);

endmodule

@@ rtl/apsp_chk.sv @@
module apsp_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           wr_en,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [apsp_pkg::AVG_W-1:0]     out_avg,
	input logic [apsp_pkg::IDX_W-1:0]     out_idx,
	input logic                           out_last
);
	import apsp_pkg::*;

	logic [IDX_W-1:0] exp_idx_q;
	logic             exp_ok_q;

	// track the next expected bin index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
			exp_ok_q  <= 1'b1;
		end else if (wr_en) begin
			exp_ok_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			exp_ok_q  <= 1'b1;
			exp_idx_q <= out_last ? '0 : IDX_W'(out_idx + 1'b1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_avg) && $stable(out_idx) && $stable(out_last))
		else $error("result word changed while stalled");

	a_idx_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && exp_ok_q |-> out_idx == exp_idx_q)
		else $error("bin index out of sequence");

	a_reset_quiet: assert property (@(posedge clk)
		$past(!arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind averaged_power_spectrum_top apsp_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.wr_en     (wr_en),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_avg   (out_ch.bin_average),
	.out_idx   (out_ch.bin_index),
	.out_last  (out_ch.last_bin)
);
